// ===== rtl/core/glm_pkg.sv =====
// ----------------------------------------------------------------------------
// Glyph cell metrics package
// Shared types and constants for the glyph cell metrics block and its checker.
// ----------------------------------------------------------------------------
package glm_pkg;

    localparam int TALLY_DEPTH_DEF = 64;

    localparam logic [7:0] GREY_LIMIT      = 8'd240;
    localparam logic [5:0] BASELINE_LIFT   = 6'd2;
    localparam logic [5:0] BASELINE_MAX    = 6'd63;
    localparam logic [7:0] SIZE_MAX        = 8'd255;

    localparam logic [7:0] CELL_WIDTH_RST  = 8'd18;
    localparam logic [5:0] CELL_HEIGHT_RST = 6'd22;

    typedef enum logic [1:0] {
        CFG_CELL_WIDTH  = 2'd0,
        CFG_CELL_HEIGHT = 2'd1,
        CFG_FIXED_WIDTH = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       new_font;
    } t_pixel;

    typedef struct packed {
        logic [7:0] glyph_offset;
        logic [7:0] glyph_size;
        logic [5:0] glyph_baseline;
        logic [5:0] dominant_baseline;
        logic       empty_cell;
    } t_metrics;

endpackage

// ===== rtl/core/glyph_cell_metrics.sv =====
// ----------------------------------------------------------------------------
// Glyph cell metrics
// Ink bounding box, baseline and dominant baseline of streamed glyph cells.
// ----------------------------------------------------------------------------
// The block accepts one pixel per clock cycle while o_in_stall is low, and
// produces one result per glyph cell, on the transfer of the cell's last
// pixel. On its way to the output, the last pixel of a cell goes through an
// input register, a cell tracking stage that updates the counters and the
// ink box and issues the histogram read, and a histogram stage that
// bumps the baseline tally and updates the dominant baseline into the output
// register. The histogram sits in a single memory with one read and one write
// port; a forwarding path covers back to back cells that hit the same
// baseline, so the full rate holds even for one pixel cells. The histogram is
// cleared at once by per entry valid bits when a pixel flagged new_font
// passes the tracking stage, so no clearing pass is needed after reset.
// Configuration is written through a simple write port and must only change
// while the pipeline is empty.
module glyph_cell_metrics
    import glm_pkg::*;
#(
    parameter int TALLY_DEPTH = TALLY_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write port
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    // pixel input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_pixel     i_in_pixel,
    // result output channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_metrics   o_out_glyph
);

    localparam int AW = $clog2(TALLY_DEPTH);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [7:0] r_cell_width;
    logic [5:0] r_cell_height;
    logic       r_fixed_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_width  <= CELL_WIDTH_RST;
            r_cell_height <= CELL_HEIGHT_RST;
            r_fixed_width <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CELL_WIDTH:  r_cell_width  <= i_cfg_data;
                CFG_CELL_HEIGHT: r_cell_height <= i_cfg_data[5:0];
                CFG_FIXED_WIDTH: r_fixed_width <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. The tracking stage only moves when the
    // histogram stage can take its item, which keeps the histogram clear
    // of a new font strictly after every update of the previous font.
    // ------------------------------------------------------------------
    logic r_px_v;
    logic r_s2_v;
    logic r_out_v;
    logic out_free;
    logic s2_go;
    logic s2_free;
    logic s1_go;

    assign out_free = !r_out_v || !i_out_stall;
    assign s2_go    = r_s2_v && out_free;
    assign s2_free  = !r_s2_v || out_free;
    assign s1_go    = r_px_v && s2_free;

    assign o_in_stall  = r_px_v && !s1_go;
    assign o_out_valid = r_out_v;

    // ------------------------------------------------------------------
    // Input register.
    // ------------------------------------------------------------------
    t_pixel r_px;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px_v <= 1'b0;
        end else if (!o_in_stall) begin
            r_px_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_px <= i_in_pixel;
        end
    end

    // ------------------------------------------------------------------
    // Cell tracking stage: position counters, ink test and ink box.
    // ------------------------------------------------------------------
    logic [7:0] r_col;
    logic [5:0] r_row;
    logic       r_alpha_mode;
    logic       r_ink_seen;
    logic [7:0] r_min_col;
    logic [7:0] r_max_col;
    logic [5:0] r_max_row;

    logic [7:0] n_col;
    logic [5:0] n_row;
    logic       n_alpha_mode;
    logic       n_ink_seen;
    logic [7:0] n_min_col;
    logic [7:0] n_max_col;
    logic [5:0] n_max_row;

    logic [7:0] px_x;
    logic [5:0] px_y;
    logic       first_px;
    logic       grey_px;
    logic       seen_before;
    logic       ink;
    logic       seen_now;
    logic [7:0] last_col;
    logic [5:0] last_row;
    logic       row_end;
    logic       cell_end;
    logic [8:0] ink_width;
    logic [6:0] base_raw;
    logic [5:0] base;
    logic       tally_en;
    logic [AW-1:0] rd_addr;
    t_metrics   s1_res;

    always_comb begin
        px_x     = r_px.new_font ? 8'd0 : r_col;
        px_y     = r_px.new_font ? 6'd0 : r_row;
        first_px = (px_x == 8'd0) && (px_y == 6'd0);
        grey_px  = (r_px.red == r_px.green) && (r_px.green == r_px.blue)
                   && (r_px.red >= GREY_LIMIT);

        // The first pixel of a cell selects the ink test for the whole cell.
        n_alpha_mode = first_px ? grey_px : r_alpha_mode;
        seen_before  = first_px ? 1'b0 : r_ink_seen;
        ink          = n_alpha_mode ? (r_px.alpha != 8'd0) : (r_px.red != 8'd0);
        seen_now     = seen_before || ink;

        n_min_col = r_min_col;
        n_max_col = r_max_col;
        n_max_row = r_max_row;
        if (ink) begin
            if (!seen_before || (px_x < r_min_col)) begin
                n_min_col = px_x;
            end
            if (!seen_before || (px_x > r_max_col)) begin
                n_max_col = px_x;
            end
            n_max_row = px_y;
        end

        // A register value of zero wraps to the widest cell.
        last_col = r_cell_width - 8'd1;
        last_row = r_cell_height - 6'd1;
        row_end  = px_x >= last_col;
        cell_end = row_end && (px_y >= last_row);

        n_col      = row_end ? 8'd0 : px_x + 8'd1;
        n_row      = row_end ? (cell_end ? 6'd0 : px_y + 6'd1) : px_y;
        n_ink_seen = cell_end ? 1'b0 : seen_now;

        ink_width = {1'b0, n_max_col} - {1'b0, n_min_col} + 9'd1;
        base_raw  = {1'b0, n_max_row} + {1'b0, BASELINE_LIFT};
        base      = base_raw[6] ? BASELINE_MAX : base_raw[5:0];
        tally_en  = seen_now && ({3'b000, base} < 9'(TALLY_DEPTH));
        rd_addr   = AW'(base);

        s1_res.glyph_offset      = seen_now ? n_min_col : 8'd0;
        s1_res.glyph_size        = !seen_now ? 8'd0 :
                                   ink_width[8] ? SIZE_MAX : ink_width[7:0];
        s1_res.glyph_baseline    = seen_now ? base : 6'd0;
        s1_res.dominant_baseline = 6'd0;
        s1_res.empty_cell        = !seen_now;
        if (r_fixed_width) begin
            s1_res.glyph_offset = 8'd0;
            s1_res.glyph_size   = r_cell_width;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col        <= 8'd0;
            r_row        <= 6'd0;
            r_alpha_mode <= 1'b0;
            r_ink_seen   <= 1'b0;
            r_min_col    <= 8'd0;
            r_max_col    <= 8'd0;
            r_max_row    <= 6'd0;
        end else if (s1_go) begin
            r_col        <= n_col;
            r_row        <= n_row;
            r_alpha_mode <= n_alpha_mode;
            r_ink_seen   <= n_ink_seen;
            r_min_col    <= n_min_col;
            r_max_col    <= n_max_col;
            r_max_row    <= n_max_row;
        end
    end

    // ------------------------------------------------------------------
    // Baseline histogram memory with per entry valid bits. An entry whose
    // valid bit is clear reads as a zero tally.
    // ------------------------------------------------------------------
    logic [7:0]             r_tally_mem [TALLY_DEPTH];
    logic [7:0]             r_tally_q;
    logic [TALLY_DEPTH-1:0] r_vld;
    logic                   r_rd_ok;
    logic                   r_fwd;
    logic [7:0]             r_fwd_data;

    t_metrics      r_s2_res;
    logic          r_s2_tally;
    logic [AW-1:0] r_s2_addr;

    logic       wr_en;
    logic [7:0] wr_data;
    logic [7:0] cur_tally;
    logic       font_clear;

    assign font_clear = s1_go && r_px.new_font;
    assign wr_en      = s2_go && r_s2_tally;
    assign cur_tally  = r_fwd ? r_fwd_data : (r_rd_ok ? r_tally_q : 8'd0);
    assign wr_data    = cur_tally + 8'd1;

    // The read data is held while the histogram stage waits on the output.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_tally_mem[r_s2_addr] <= wr_data;
        end
        if (s2_free) begin
            r_tally_q <= r_tally_mem[rd_addr];
        end
    end

    // A write by the histogram stage in the same cycle as the read for the
    // next cell is forwarded. The clear of a new font wins over that write,
    // since the write belongs to the font before.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (font_clear) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[r_s2_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free) begin
            r_rd_ok    <= !r_px.new_font && r_vld[rd_addr];
            r_fwd      <= !r_px.new_font && wr_en && (r_s2_addr == rd_addr);
            r_fwd_data <= wr_data;
            r_s2_res   <= s1_res;
            r_s2_tally <= tally_en;
            r_s2_addr  <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s2_free) begin
            r_s2_v <= s1_go && cell_end;
        end
    end

    // ------------------------------------------------------------------
    // Histogram stage: tally update and dominant baseline. The tally of the
    // dominant baseline is kept beside it, so one memory read suffices.
    // ------------------------------------------------------------------
    logic [5:0] r_best;
    logic [7:0] r_best_cnt;
    logic [5:0] n_best;
    logic [7:0] n_best_cnt;
    t_metrics   s2_res;

    always_comb begin
        n_best     = r_best;
        n_best_cnt = r_best_cnt;
        if (r_s2_tally) begin
            if (r_s2_res.glyph_baseline == r_best) begin
                n_best_cnt = wr_data;
            end else if (wr_data > r_best_cnt) begin
                n_best     = r_s2_res.glyph_baseline;
                n_best_cnt = wr_data;
            end
        end
        s2_res                   = r_s2_res;
        s2_res.dominant_baseline = n_best;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best     <= 6'd0;
            r_best_cnt <= 8'd0;
        end else if (font_clear) begin
            r_best     <= 6'd0;
            r_best_cnt <= 8'd0;
        end else if (s2_go) begin
            r_best     <= n_best;
            r_best_cnt <= n_best_cnt;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    t_metrics r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_free) begin
            r_out_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= s2_res;
        end
    end

    assign o_out_glyph = r_out;

endmodule

// ===== rtl/core/glm_checker.sv =====
// ----------------------------------------------------------------------------
// Glyph cell metrics checker
// Port level assertions on the result channel of the glyph cell metrics block.
// ----------------------------------------------------------------------------
module glm_checker
    import glm_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_metrics o_out_glyph
);

    // A stalled result stays on the port unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_glyph))
        else $error("result changed while stalled");

    // An empty cell reports no baseline.
    a_empty_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_glyph.empty_cell |-> o_out_glyph.glyph_baseline == 6'd0)
        else $error("empty cell with nonzero baseline");

    // An empty cell reports no offset, also in fixed width mode.
    a_empty_offs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_glyph.empty_cell |-> o_out_glyph.glyph_offset == 8'd0)
        else $error("empty cell with nonzero offset");

    // A cell with ink sits at least two rows above the baseline origin.
    a_ink_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_glyph.empty_cell |-> o_out_glyph.glyph_baseline >= BASELINE_LIFT)
        else $error("inked cell with baseline below two");

endmodule

bind glyph_cell_metrics glm_checker u_glm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_glyph (o_out_glyph)
);
